FILE: rtl/fir_filter_16_tap_macros.svh
// ----------------------------------------------------------------------------
// FIR filter assertion macros
// Shared assertion shorthands for the FIR filter RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_16_TAP_MACROS_SVH
`define FIR_FILTER_16_TAP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define FIR_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("FIR assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FIR_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("FIR assertion failed");

`else

`define FIR_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define FIR_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

FILE: rtl/fir16_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Types, constants and the output rounding function of the FIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package fir16_pkg;

  localparam int SampleW  = 16;
  localparam int AccW     = 36;
  localparam int CoefRegs = 8;
  localparam int CoefTaps = 2 * CoefRegs;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 32;
  localparam int CoefSelW = $clog2(CoefRegs);

  typedef logic signed [SampleW-1:0]  sample_t;
  typedef logic signed [SampleW-1:0]  coef_t;
  typedef logic signed [AccW-1:0]     acc_t;
  typedef logic        [CfgDataW-1:0] coef_pair_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Rounds a Q6.30 sum to Q1.15 (halves go up) and saturates to 16 bits.
  function automatic sample_t round_sat(input acc_t acc);
    logic signed [AccW:0]    biased;
    logic signed [AccW-15:0] shifted;
    biased  = {acc[AccW-1], acc} + 37'sd16384;
    shifted = biased[AccW:15];
    if (shifted > 22'sd32767) begin
      return 16'sh7fff;
    end else if (shifted < -22'sd32768) begin
      return 16'sh8000;
    end else begin
      return shifted[SampleW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fir16_cell.sv
// ----------------------------------------------------------------------------
// FIR filter tap cell
// Holds one delayed sample and adds its weighted product to the passing sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fir16_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift_en,
  input  wire fir16_pkg::sample_t prev_sample,
  input  wire fir16_pkg::coef_t   coef,
  input  wire fir16_pkg::acc_t    sum_in,
  output fir16_pkg::sample_t     sample_q,
  output fir16_pkg::acc_t        sum_q
);

  fir16_pkg::sample_t sample_r, sample_nxt;
  fir16_pkg::acc_t    sum_r, sum_nxt;
  logic signed [2*fir16_pkg::SampleW-1:0] prod;

  always_comb begin
    sample_nxt = shift_en ? prev_sample : sample_r;
    prod       = coef * sample_r;
    // The sum wraps within the accumulator width.
    sum_nxt    = sum_in + fir16_pkg::acc_t'(prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sample_q = sample_r;
  assign sum_q    = sum_r;

endmodule

`default_nettype wire

FILE: rtl/fir_filter_16_tap.sv
// ----------------------------------------------------------------------------
// 16-tap FIR filter
// Direct-form fixed-point FIR filter built as a row of tap cells.
// ----------------------------------------------------------------------------
// Each accepted sample is shifted into a delay line of TAPS cells and produces
// exactly one output: the sum of coefficient times delayed sample over all
// taps, accumulated in 36-bit Q6.30, rounded to Q1.15 with halves going up
// and saturated to the signed 16-bit range. After an input transfer the
// partial sum walks down the cell row one cell per clock, and the done state
// then loads the output register once that register is free; no new sample
// is taken before that load. A finished result waits in that register, so
// the next sample is taken while the previous result has not yet been
// transferred. The sixteen coefficients sit in eight configuration words,
// two taps each with the lower tap in bits 15..0; they reset to zero, so the
// output reads zero until they are written. Taps beyond sixteen have a zero
// coefficient but their samples still move through the delay line.
`default_nettype none

`include "fir_filter_16_tap_macros.svh"

module fir_filter_16_tap #(
  parameter int TAPS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input sample channel.
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire fir16_pkg::sample_t                   in_sample_in,
  // Filtered sample channel.
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output fir16_pkg::sample_t                        out_filtered_sample,
  // Coefficient write port.
  input  wire logic                                 cfg_wr_en,
  input  wire logic [fir16_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [fir16_pkg::CfgDataW-1:0]       cfg_wdata
);

  localparam int CntW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(TAPS - 1);

  // Coefficient registers.
  fir16_pkg::coef_pair_t coef_pair_r   [fir16_pkg::CoefRegs];
  fir16_pkg::coef_pair_t coef_pair_nxt [fir16_pkg::CoefRegs];

  // Control state.
  fir16_pkg::state_t state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              shift_en;
  logic              load_out;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  fir16_pkg::sample_t out_data_r, out_data_nxt;

  // Links between neighboring cells.
  fir16_pkg::sample_t sample_chain [TAPS];
  fir16_pkg::acc_t    sum_chain    [TAPS];
  fir16_pkg::coef_t   coef_tap     [TAPS];

  // A write to an index past the last coefficient word is dropped.
  always_comb begin
    for (int k = 0; k < fir16_pkg::CoefRegs; k++) begin
      coef_pair_nxt[k] = coef_pair_r[k];
    end
    if (cfg_wr_en && (cfg_index < fir16_pkg::CfgIdxW'(fir16_pkg::CoefRegs))) begin
      coef_pair_nxt[cfg_index[fir16_pkg::CoefSelW-1:0]] = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < fir16_pkg::CoefRegs; k++) begin
        coef_pair_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < fir16_pkg::CoefRegs; k++) begin
        coef_pair_r[k] <= coef_pair_nxt[k];
      end
    end
  end

  // The row of tap cells. Cell 0 takes the new sample and starts the sum at
  // zero; every other cell takes its sample and partial sum from its left
  // neighbor. The samples only move on an input transfer, while the sums
  // advance every clock, so the last cell's sum is complete once the partial
  // sum has passed every cell and then stays steady until the next shift.
  for (genvar i = 0; i < TAPS; i++) begin : g_tap
    fir16_pkg::sample_t prev_sample;
    fir16_pkg::acc_t    sum_in;

    if (i < fir16_pkg::CoefTaps) begin : g_coef
      assign coef_tap[i] = coef_pair_r[i / 2][(i % 2) * fir16_pkg::SampleW +: fir16_pkg::SampleW];
    end else begin : g_zero
      assign coef_tap[i] = '0;
    end

    if (i == 0) begin : g_head
      assign prev_sample = in_sample_in;
      assign sum_in      = '0;
    end else begin : g_body
      assign prev_sample = sample_chain[i-1];
      assign sum_in      = sum_chain[i-1];
    end

    fir16_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift_en    (shift_en),
      .prev_sample (prev_sample),
      .coef        (coef_tap[i]),
      .sum_in      (sum_in),
      .sample_q    (sample_chain[i]),
      .sum_q       (sum_chain[i])
    );
  end

  // Sequencer: wait for a sample, let the sum walk the row, then hand the
  // rounded result to the output register as soon as that register is free.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    shift_en  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      fir16_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          shift_en  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = fir16_pkg::ST_RUN;
        end
      end
      fir16_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CntLast) begin
          state_nxt = fir16_pkg::ST_DONE;
        end
      end
      fir16_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = fir16_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fir16_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fir16_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Output register: a result is held until its transfer completes.
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = fir16_pkg::round_sat(sum_chain[TAPS-1]);
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_data_nxt  = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_data_r;

  // An input transfer starts the sum walk from the first cell.
  `FIR_ASSERT_NEXT(a_accept_starts_run, clk, rst_n, in_valid && in_ready, (state_r == fir16_pkg::ST_RUN) && (cnt_r == '0) && !in_ready)
  // The walk ends after the last cell has added its product.
  `FIR_ASSERT_NEXT(a_run_ends, clk, rst_n, (state_r == fir16_pkg::ST_RUN) && (cnt_r == CntLast), state_r == fir16_pkg::ST_DONE)
  // A finished sum reaches the output as soon as the output register is free.
  `FIR_ASSERT_NEXT(a_done_loads, clk, rst_n, (state_r == fir16_pkg::ST_DONE) && (!out_valid_r || out_ready), out_valid_r && (state_r == fir16_pkg::ST_IDLE))
  // The sum walk never outruns the row.
  `FIR_ASSERT_IMPLY(a_cnt_in_range, clk, rst_n, state_r == fir16_pkg::ST_RUN, cnt_r <= CntLast)

endmodule

`default_nettype wire

FILE: tb/fir_filter_16_tap_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIR filter 16-tap testbench
// Streams samples through the filter under several coefficient loads and
// idle patterns, and checks every output against a bit-exact predictor.
// ----------------------------------------------------------------------------
// A driver and a monitor run as clocked always blocks. The driver changes the
// input channel on the falling edge and pulls samples from a queue that the
// stimulus block fills. The monitor samples both channels on the rising edge:
// every accepted input transfer runs the predictor and pushes the expected
// output, and every accepted output transfer is compared against the oldest
// expected output. Coefficient loads happen only once the filter has drained.

module fir_filter_16_tap_tb;

  // The filter is built with sixteen taps, so every tap has a coefficient.
  localparam int Taps = 16;

  typedef enum {
    COEF_ZERO,
    COEF_STANDARD,
    COEF_RANDOM,
    COEF_MAX,
    COEF_MIN,
    COEF_ONES
  } coef_kind_e;

  typedef enum {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  logic                           clk;
  logic                           rst_n        = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_ready;
  fir16_pkg::sample_t             in_sample_in = '0;
  logic                           out_valid;
  logic                           out_ready    = 1'b0;
  fir16_pkg::sample_t             out_filtered_sample;
  logic                           cfg_wr_en    = 1'b0;
  logic [fir16_pkg::CfgIdxW-1:0]  cfg_index    = '0;
  logic [fir16_pkg::CfgDataW-1:0] cfg_wdata    = '0;

  // Samples waiting for the driver, and predicted outputs waiting for the monitor.
  fir16_pkg::sample_t     sample_q[$];
  fir16_pkg::sample_t     filtered_q[$];

  // Predictor state: its own copy of the delay line and the coefficient words.
  fir16_pkg::sample_t     delay_model [Taps];
  fir16_pkg::coef_pair_t  coef_model  [fir16_pkg::CoefRegs];
  fir16_pkg::coef_t       std_taps    [fir16_pkg::CoefTaps];

  // Set at a rising edge when the input transfer completed, so the driver can
  // move on to the next sample at the following falling edge.
  logic        in_fire = 1'b0;

  int unsigned src_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned queued_cnt    = 0;
  int unsigned accepted_cnt  = 0;
  int unsigned checked_cnt   = 0;
  int unsigned sat_hi_cnt    = 0;
  int unsigned sat_lo_cnt    = 0;
  int unsigned coef_loads    = 0;
  int unsigned err_cnt       = 0;

  fir_filter_16_tap #(
    .TAPS(Taps)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_in       (in_sample_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_sample(out_filtered_sample),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // This stops the run if the filter hangs.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic flag_error(input string msg);
    err_cnt++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Shifts a new sample into the modeled delay line and returns the filter
  // output: the sum of coefficient times sample over all taps in a 36-bit
  // Q6.30 accumulator, rounded to Q1.15 with halves going up, then clamped.
  function automatic fir16_pkg::sample_t filter_sample(input fir16_pkg::sample_t smp);
    fir16_pkg::acc_t                 acc;
    fir16_pkg::acc_t                 prod;
    fir16_pkg::coef_t                c;
    logic signed [fir16_pkg::AccW:0] biased;
    logic signed [fir16_pkg::AccW:0] quot;
    for (int t = Taps - 1; t > 0; t--) begin
      delay_model[t] = delay_model[t-1];
    end
    delay_model[0] = smp;
    acc = '0;
    for (int t = 0; t < Taps; t++) begin
      // Taps past the sixteenth have no register and so a zero coefficient.
      c = (t < fir16_pkg::CoefTaps) ?
          fir16_pkg::coef_t'(coef_model[t/2][(t%2)*16 +: 16]) : '0;
      prod = c * delay_model[t];
      acc = acc + prod;
    end
    biased = acc + 37'sd16384;
    quot = biased >>> 15;
    if (quot > 37'sd32767) begin
      return 16'sh7fff;
    end else if (quot < -37'sd32768) begin
      return 16'sh8000;
    end else begin
      return fir16_pkg::sample_t'(quot);
    end
  endfunction

  // Input driver: presents the next queued sample, holds it until the
  // transfer, and inserts idle cycles at the current idle rate.
  always @(negedge clk) begin : driver
    logic               nxt_valid;
    fir16_pkg::sample_t nxt_sample;
    nxt_valid  = in_valid;
    nxt_sample = in_sample_in;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && in_fire) begin
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && sample_q.size() != 0 &&
          $urandom_range(99) >= src_idle_pct) begin
        nxt_valid  = 1'b1;
        nxt_sample = sample_q.pop_front();
      end
    end
    in_valid     <= nxt_valid;
    in_sample_in <= nxt_sample;
    out_ready    <= rst_n && ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: tracks coefficient writes and input transfers in the predictor,
  // and checks each output transfer against the oldest prediction.
  always @(posedge clk) begin : monitor
    fir16_pkg::sample_t want;
    if (!rst_n) begin
      for (int t = 0; t < Taps; t++) begin
        delay_model[t] = '0;
      end
      for (int r = 0; r < fir16_pkg::CoefRegs; r++) begin
        coef_model[r] = '0;
      end
      in_fire <= 1'b0;
    end else begin
      // Writes to indexes past the last coefficient word are dropped.
      if (cfg_wr_en && cfg_index < fir16_pkg::CoefRegs) begin
        coef_model[cfg_index] = cfg_wdata;
      end
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        filtered_q.push_back(filter_sample(in_sample_in));
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          flag_error($sformatf("output %0d with no sample pending", out_filtered_sample));
        end else begin
          want = filtered_q.pop_front();
          checked_cnt++;
          if (out_filtered_sample !== want) begin
            flag_error($sformatf("output %0d, predicted %0d (output #%0d)",
                                 out_filtered_sample, want, checked_cnt));
          end
          if (want == 16'sh7fff) sat_hi_cnt++;
          if (want == 16'sh8000) sat_lo_cnt++;
        end
      end
    end
  end

  task automatic send_sample(input fir16_pkg::sample_t smp);
    sample_q.push_back(smp);
    queued_cnt++;
  endtask

  // Blocks until every queued sample has been taken and every output seen.
  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_cnt != queued_cnt || filtered_q.size() != 0);
  endtask

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      IDLE_SRC: begin
        src_idle_pct   = 88;
        sink_stall_pct = 0;
      end
      IDLE_SINK: begin
        src_idle_pct   = 0;
        sink_stall_pct = 88;
      end
      default: begin
        src_idle_pct   = 7;
        sink_stall_pct = 7;
      end
    endcase
  endtask

  // Writes all eight coefficient words back to back, plus one write to an
  // unused index that the filter must ignore. Called only when drained.
  task automatic load_coefs(input coef_kind_e kind);
    fir16_pkg::coef_t              taps [fir16_pkg::CoefTaps];
    logic [15:0]                   raw;
    logic [fir16_pkg::CfgIdxW-1:0] junk_idx;
    for (int t = 0; t < fir16_pkg::CoefTaps; t++) begin
      raw = 16'($urandom);
      case (kind)
        COEF_ZERO:     taps[t] = '0;
        COEF_STANDARD: taps[t] = std_taps[t];
        COEF_MAX:      taps[t] = 16'sh7fff;
        COEF_MIN:      taps[t] = 16'sh8000;
        COEF_ONES:     taps[t] = 16'shffff;
        // Random taps are scaled down at random so the sum does not always clip.
        default:       taps[t] = $signed(raw) >>> $urandom_range(4, 0);
      endcase
    end
    junk_idx = fir16_pkg::CfgIdxW'($urandom_range(2**fir16_pkg::CfgIdxW - 1,
                                                  fir16_pkg::CoefRegs));
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= junk_idx;
    cfg_wdata <= $urandom;
    for (int r = 0; r < fir16_pkg::CoefRegs; r++) begin
      @(negedge clk);
      cfg_index <= fir16_pkg::CfgIdxW'(r);
      cfg_wdata <= {taps[2*r+1], taps[2*r]};
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    coef_loads++;
  endtask

  // Mostly full-range samples, with rail values and small amplitudes mixed in.
  function automatic fir16_pkg::sample_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      case ($urandom_range(4))
        0:       return 16'sh7fff;
        1:       return 16'sh8000;
        2:       return 16'sh0000;
        3:       return 16'sh0001;
        default: return 16'shffff;
      endcase
    end else if (pick < 27) begin
      return fir16_pkg::sample_t'(int'($urandom_range(511)) - 256);
    end
    return fir16_pkg::sample_t'($urandom);
  endfunction

  initial begin : stimulus
    coef_kind_e phase_kind [8];
    std_taps = '{16'sd161, 16'sd269, -16'sd1202, -16'sd1744, -16'sd1226, -16'sd8920,
                 16'sd2056, 16'sd20335, 16'sd2056, -16'sd8920, -16'sd1226, -16'sd1744,
                 -16'sd1202, 16'sd269, 16'sd161, 16'sd194};
    phase_kind = '{COEF_STANDARD, COEF_RANDOM, COEF_MIN, COEF_RANDOM,
                   COEF_MAX, COEF_ONES, COEF_STANDARD, COEF_RANDOM};

    // Synchronous reset, released on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idle(IDLE_NONE);

    // Coefficients reset to zero, so the rails still give zero outputs.
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0001);
    wait_drained();
    load_coefs(COEF_ZERO);

    // Standard taps: a full-scale impulse followed by zeros walks
    // every coefficient out through the rounding stage.
    load_coefs(COEF_STANDARD);
    send_sample(16'sh7fff);
    for (int k = 0; k < fir16_pkg::CoefTaps - 1; k++) begin
      send_sample(16'sh0000);
    end
    wait_drained();

    // Full-scale taps: two positive samples clip at the top rail, then four
    // negative ones pull the sum past the bottom rail.
    load_coefs(COEF_MAX);
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    repeat (4) send_sample(16'sh8000);
    wait_drained();

    // Random part: eight phases, each with its own coefficient load and one
    // of the four idle patterns. Every phase starts from a drained filter.
    for (int p = 0; p < 8; p++) begin
      load_coefs(phase_kind[p]);
      set_idle(idle_mode_e'(p % 4));
      repeat (128) send_sample(rand_sample());
      wait_drained();
    end

    // The filter holds no work once the last output is out; give it a short
    // tail anyway to catch any stray output transfer.
    set_idle(IDLE_NONE);
    repeat (2 * (Taps + 2)) @(negedge clk);

    $display("Sent %0d samples and checked %0d outputs over %0d coefficient loads.",
             accepted_cnt, checked_cnt, coef_loads);
    $display("Outputs clipped high %0d and low %0d times; %0d mismatches.",
             sat_hi_cnt, sat_lo_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
